// ===== hdl/eab_pkg.sv =====
// shared types, constants and arithmetic helpers for the euler to basis block
`timescale 1ns / 1ps
package eab_pkg;

    localparam int OUT_FRAC_BITS = 14;
    localparam int SINCOS_STAGES = 16;
    localparam int NUM_STAGES    = (SINCOS_STAGES < 32) ? SINCOS_STAGES : 32;
    localparam int REDUCE_LAT    = 4;
    localparam int COMBINE_LAT   = 4;
    localparam int PIPE_LAT      = REDUCE_LAT + NUM_STAGES + COMBINE_LAT;

    localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
    localparam logic signed [34:0] OUT_RND = (OUT_SHIFT > 0) ?
        35'sd1 <<< ((OUT_SHIFT > 0) ? (OUT_SHIFT - 1) : 0) : 35'sd0;
    localparam logic signed [34:0] OUT_LIM = 35'sd1 <<< OUT_FRAC_BITS;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [29:0] ATAN_Q30 [0:31] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
    } lane_t;

    typedef lane_t [2:0] cell_t;

    // q2.30 product rounded half up back to q2.30
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = a * b + 64'sd536870912;
            return p[61:30];
        end
    endfunction

    // round to output precision, clamp to unit range, 16 bit pattern
    function automatic logic [15:0] to_out(input logic signed [33:0] v);
        logic signed [34:0] s;
        logic signed [34:0] r;
        begin
            s = 35'(v) + OUT_RND;
            r = s >>> OUT_SHIFT;
            if (r > OUT_LIM)
                r = OUT_LIM;
            if (r < -OUT_LIM)
                r = -OUT_LIM;
            return r[15:0];
        end
    endfunction

endpackage

// ===== hdl/eab_reduce.sv =====
// angle reduction: wrap to one turn, split quadrant, convert remainder to q2.30 radians
`timescale 1ns / 1ps
module eab_reduce (
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  angle,
    output eab_pkg::lane_t      lane
);

    logic [14:0] r;
    logic [1:0]  q_next;
    logic [12:0] f_next;

    logic [1:0]  q1_reg;
    logic [12:0] f1_reg;
    logic [1:0]  q2_reg;
    logic [30:0] a2_reg;
    logic [25:0] x2_reg;
    logic [1:0]  q3_reg;
    logic [30:0] a3_reg;
    logic [25:0] x3_reg;
    logic [11:0] d3_reg;
    logic [1:0]  q4_reg;
    logic [30:0] z4_reg;

    logic signed [17:0] a18;
    logic signed [17:0] w18;
    logic [52:0]        recip_prod;
    logic [25:0]        rem;
    logic [30:0]        z_next;

    // wrap into one turn
    always_comb
    begin
        a18 = 18'(angle);
        if (a18 < -18'sd23040)
            w18 = a18 + 18'sd46080;
        else if (a18 < 18'sd0)
            w18 = a18 + 18'sd23040;
        else if (a18 >= 18'sd23040)
            w18 = a18 - 18'sd23040;
        else
            w18 = a18;
        r = w18[14:0];
        if (r >= 15'd17280)
        begin
            q_next = 2'd3;
            f_next = 13'(r - 15'd17280);
        end
        else if (r >= 15'd11520)
        begin
            q_next = 2'd2;
            f_next = 13'(r - 15'd11520);
        end
        else if (r >= 15'd5760)
        begin
            q_next = 2'd1;
            f_next = 13'(r - 15'd5760);
        end
        else
        begin
            q_next = 2'd0;
            f_next = r[12:0];
        end
    end

    // quotient by 11520 through reciprocal, then one correction step
    assign recip_prod = 53'(x2_reg) * 53'd95443717;
    assign rem        = x3_reg - 26'(d3_reg * 26'd11520);
    assign z_next     = a3_reg + 31'(d3_reg) + ((rem >= 26'd11520) ? 31'd1 : 31'd0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg <= q_next;
            f1_reg <= f_next;
            q2_reg <= q1_reg;
            a2_reg <= 31'(f1_reg * 31'd292817);
            x2_reg <= 26'(f1_reg * 26'd7586) + 26'd5760;
            q3_reg <= q2_reg;
            a3_reg <= a2_reg;
            x3_reg <= x2_reg;
            d3_reg <= recip_prod[51:40];
            q4_reg <= q3_reg;
            z4_reg <= z_next;
        end
    end

    assign lane.x    = eab_pkg::CORDIC_GAIN;
    assign lane.y    = '0;
    assign lane.z    = 33'(z4_reg);
    assign lane.quad = q4_reg;

endmodule

// ===== hdl/eab_cordic_cell.sv =====
// one rotation-mode cordic step for the three angles
`timescale 1ns / 1ps
module eab_cordic_cell (
    input  logic            clk,
    input  logic            en,
    input  logic [4:0]      step,
    input  eab_pkg::cell_t  din,
    output eab_pkg::cell_t  dout
);

    eab_pkg::cell_t data_next;
    eab_pkg::cell_t data_reg;
    logic signed [32:0] atan_step;

    assign atan_step = 33'(eab_pkg::ATAN_Q30[step]);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            data_next[k].quad = din[k].quad;
            if (!din[k].z[32])
            begin
                data_next[k].x = din[k].x - (din[k].y >>> step);
                data_next[k].y = din[k].y + (din[k].x >>> step);
                data_next[k].z = din[k].z - atan_step;
            end
            else
            begin
                data_next[k].x = din[k].x + (din[k].y >>> step);
                data_next[k].y = din[k].y - (din[k].x >>> step);
                data_next[k].z = din[k].z + atan_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

// ===== hdl/eab_combine.sv =====
// quadrant mapping, products of sines and cosines, output rounding and clamp
`timescale 1ns / 1ps
module eab_combine (
    input  logic            clk,
    input  logic            en,
    input  eab_pkg::cell_t  din,
    output logic [15:0]     forward_x,
    output logic [15:0]     forward_y,
    output logic [15:0]     forward_z,
    output logic [15:0]     right_x,
    output logic [15:0]     right_y,
    output logic [15:0]     right_z,
    output logic [15:0]     up_x,
    output logic [15:0]     up_y,
    output logic [15:0]     up_z
);

    logic signed [31:0] s_next [3];
    logic signed [31:0] c_next [3];
    logic signed [31:0] s_reg  [3];
    logic signed [31:0] c_reg  [3];

    // second stage: pairwise products
    logic signed [31:0] t_reg, u_reg, cpcy_reg, cpsy_reg, crsy_reg, crcy_reg;
    logic signed [31:0] srcp_reg, srsy_reg, srcy_reg, crcp_reg, sp2_reg, sy2_reg, cy2_reg;

    // third stage: triple products and carried terms
    logic signed [31:0] tcy_reg, tsy_reg, ucy_reg, usy_reg;
    logic signed [31:0] cpcy3_reg, cpsy3_reg, crsy3_reg, crcy3_reg;
    logic signed [31:0] srcp3_reg, srsy3_reg, srcy3_reg, crcp3_reg, sp3_reg;

    logic [15:0] fx_reg, fy_reg, fz_reg, rx_reg, ry_reg, rz_reg, ux_reg, uy_reg, uz_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (din[k].quad)
                2'd0:
                begin
                    s_next[k] = din[k].y[31:0];
                    c_next[k] = din[k].x[31:0];
                end
                2'd1:
                begin
                    s_next[k] = din[k].x[31:0];
                    c_next[k] = -din[k].y[31:0];
                end
                2'd2:
                begin
                    s_next[k] = -din[k].y[31:0];
                    c_next[k] = -din[k].x[31:0];
                end
                default:
                begin
                    s_next[k] = -din[k].x[31:0];
                    c_next[k] = din[k].y[31:0];
                end
            endcase
        end
    end

    // lane order: pitch, yaw, roll
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k] <= s_next[k];
                c_reg[k] <= c_next[k];
            end

            t_reg    <= eab_pkg::mulq(s_reg[2], s_reg[0]);
            u_reg    <= eab_pkg::mulq(c_reg[2], s_reg[0]);
            cpcy_reg <= eab_pkg::mulq(c_reg[0], c_reg[1]);
            cpsy_reg <= eab_pkg::mulq(c_reg[0], s_reg[1]);
            crsy_reg <= eab_pkg::mulq(c_reg[2], s_reg[1]);
            crcy_reg <= eab_pkg::mulq(c_reg[2], c_reg[1]);
            srcp_reg <= eab_pkg::mulq(s_reg[2], c_reg[0]);
            srsy_reg <= eab_pkg::mulq(s_reg[2], s_reg[1]);
            srcy_reg <= eab_pkg::mulq(s_reg[2], c_reg[1]);
            crcp_reg <= eab_pkg::mulq(c_reg[2], c_reg[0]);
            sp2_reg  <= s_reg[0];
            sy2_reg  <= s_reg[1];
            cy2_reg  <= c_reg[1];

            tcy_reg   <= eab_pkg::mulq(t_reg, cy2_reg);
            tsy_reg   <= eab_pkg::mulq(t_reg, sy2_reg);
            ucy_reg   <= eab_pkg::mulq(u_reg, cy2_reg);
            usy_reg   <= eab_pkg::mulq(u_reg, sy2_reg);
            cpcy3_reg <= cpcy_reg;
            cpsy3_reg <= cpsy_reg;
            crsy3_reg <= crsy_reg;
            crcy3_reg <= crcy_reg;
            srcp3_reg <= srcp_reg;
            srsy3_reg <= srsy_reg;
            srcy3_reg <= srcy_reg;
            crcp3_reg <= crcp_reg;
            sp3_reg   <= sp2_reg;

            fx_reg <= eab_pkg::to_out(34'(cpcy3_reg));
            fy_reg <= eab_pkg::to_out(34'(cpsy3_reg));
            fz_reg <= eab_pkg::to_out(-34'(sp3_reg));
            rx_reg <= eab_pkg::to_out(34'(crsy3_reg) - 34'(tcy_reg));
            ry_reg <= eab_pkg::to_out(-34'(tsy_reg) - 34'(crcy3_reg));
            rz_reg <= eab_pkg::to_out(-34'(srcp3_reg));
            ux_reg <= eab_pkg::to_out(34'(ucy_reg) + 34'(srsy3_reg));
            uy_reg <= eab_pkg::to_out(34'(usy_reg) - 34'(srcy3_reg));
            uz_reg <= eab_pkg::to_out(34'(crcp3_reg));
        end
    end

    assign forward_x = fx_reg;
    assign forward_y = fy_reg;
    assign forward_z = fz_reg;
    assign right_x   = rx_reg;
    assign right_y   = ry_reg;
    assign right_z   = rz_reg;
    assign up_x      = ux_reg;
    assign up_y      = uy_reg;
    assign up_z      = uz_reg;

endmodule

// ===== hdl/euler_angles_to_basis_vectors.sv =====
// top level: euler angles to forward, right and up unit vectors
`timescale 1ns / 1ps
// usage
//   input channel in_valid / in_ready carries pitch, yaw and roll, signed,
//   1/64 degree; any 16 bit pattern is taken and wrapped modulo one turn
//   output channel out_valid / out_ready carries the nine q1.14 components
//   of the forward, right and up vectors, each clamped to plus or minus one
//   the path from input transfer to output valid runs through the angle
//   reduction registers, sixteen cordic cells, then the product and rounding registers
//   throughput is one item per cycle while the pipeline moves; every stage is a register, so a new
//   item enters each cycle the pipeline moves
//   the pipeline moves whenever the output register is empty or its result is
//   being taken; while the receiver stalls with a result waiting, the whole
//   pipeline holds and in_ready falls, and nothing is lost or repeated
//   bubbles inside the pipeline are carried as cleared valid bits
//   reset clears every valid bit; data registers are not reset
module euler_angles_to_basis_vectors (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  pitch_angle,
    input  logic signed [15:0]  yaw_angle,
    input  logic signed [15:0]  roll_angle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  forward_x,
    output logic signed [15:0]  forward_y,
    output logic signed [15:0]  forward_z,
    output logic signed [15:0]  right_x,
    output logic signed [15:0]  right_y,
    output logic signed [15:0]  right_z,
    output logic signed [15:0]  up_x,
    output logic signed [15:0]  up_y,
    output logic signed [15:0]  up_z
);

    localparam int LAT = eab_pkg::PIPE_LAT;
    localparam int NST = eab_pkg::NUM_STAGES;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    eab_pkg::cell_t cell_data [0:NST];

    // global advance: output free or its transfer happening
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign out_valid = vld_reg[LAT-1];

    // one reduction unit per angle, lanes: pitch, yaw, roll
    eab_reduce u_red_pitch (
        .clk   (clk),
        .en    (en),
        .angle (pitch_angle),
        .lane  (cell_data[0][0])
    );

    eab_reduce u_red_yaw (
        .clk   (clk),
        .en    (en),
        .angle (yaw_angle),
        .lane  (cell_data[0][1])
    );

    eab_reduce u_red_roll (
        .clk   (clk),
        .en    (en),
        .angle (roll_angle),
        .lane  (cell_data[0][2])
    );

    // row of cordic cells, each hands its rotated vector to the next
    for (genvar g = 0; g < NST; g++)
    begin : g_cell
        eab_cordic_cell u_cell (
            .clk  (clk),
            .en   (en),
            .step (5'(g)),
            .din  (cell_data[g]),
            .dout (cell_data[g+1])
        );
    end

    eab_combine u_comb (
        .clk       (clk),
        .en        (en),
        .din       (cell_data[NST]),
        .forward_x (forward_x),
        .forward_y (forward_y),
        .forward_z (forward_z),
        .right_x   (right_x),
        .right_y   (right_y),
        .right_z   (right_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z)
    );

    // an input transfer always lands in the first valid slot
    a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted item missing from pipeline");

    // a stalled output holds the whole pipeline
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    a_fz_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (forward_z <= 16'sd16384 && forward_z >= -16'sd16384))
        else $error("forward_z outside unit range");

    a_uz_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (up_z <= 16'sd16384 && up_z >= -16'sd16384))
        else $error("up_z outside unit range");

endmodule
